@@ design/vlsr_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the vertex sorter.
package vlsr_pkg;

    localparam int VLSR_MAX_VERTICES = 1024;
    localparam int VLSR_COORD_WIDTH  = 32;

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_READ = 2'd1;
    localparam logic [1:0] FUNC_TRI  = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_RANGE      = 2'd1;
    localparam logic [1:0] ST_NOT_SORTED = 2'd2;
    localparam logic [1:0] ST_FULL       = 2'd3;

    localparam logic [4:0] CMD_NONE       = 5'd0;
    localparam logic [4:0] CMD_ACCEPT     = 5'd1;
    localparam logic [4:0] CMD_SORT_START = 5'd2;
    localparam logic [4:0] CMD_INIT       = 5'd3;
    localparam logic [4:0] CMD_PASS_START = 5'd4;
    localparam logic [4:0] CMD_PASS_END   = 5'd5;
    localparam logic [4:0] CMD_RUN_START  = 5'd6;
    localparam logic [4:0] CMD_RUN_END    = 5'd7;
    localparam logic [4:0] CMD_RD_ID      = 5'd8;
    localparam logic [4:0] CMD_RD_CRD     = 5'd9;
    localparam logic [4:0] CMD_MERGE      = 5'd10;
    localparam logic [4:0] CMD_MAP_RD     = 5'd11;
    localparam logic [4:0] CMD_MAP_WR     = 5'd12;
    localparam logic [4:0] CMD_SORT_END   = 5'd13;
    localparam logic [4:0] CMD_RANK_RD    = 5'd14;
    localparam logic [4:0] CMD_RANK_CRD   = 5'd15;
    localparam logic [4:0] CMD_RANK_CAP   = 5'd16;
    localparam logic [4:0] CMD_TRI0       = 5'd17;
    localparam logic [4:0] CMD_TRI1       = 5'd18;
    localparam logic [4:0] CMD_TRI2       = 5'd19;
    localparam logic [4:0] CMD_TRI3       = 5'd20;
    localparam logic [4:0] CMD_RESP       = 5'd21;

    typedef struct packed {
        logic [4:0] op;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       last;
        logic       ok;
        logic       o_ge_n;
        logic       width_done;
        logic       lo_done;
        logic       run_done;
        logic       out_free;
    } t_status;

endpackage

@@ design/vertex_lex_sort_remap_top.sv @@
// Top level of the vertex sorter: controller, datapath and checks.
// A load, read or triangle item passes through controller states to its result; any item waits
// further while the previous result is still held by a stalled output register.
// A load flagged last adds the sort: index setup, ceil(log2 N) merge passes over runs, then the
// old-to-new map; the dual-read coordinate memories supply both merge candidates for each step.
// One item is in work at a time. Synchronous active-low reset clears count, sorted flag and
// result valid; the memories are not cleared and are only read where written.
module vertex_lex_sort_remap_top import vlsr_pkg::*; #(
    parameter int MAX_VERTICES = VLSR_MAX_VERTICES,
    parameter int COORD_WIDTH  = VLSR_COORD_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_func,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_y_coord,
    input  logic signed [31:0] i_z_coord,
    input  logic               i_last_vertex,
    input  logic [9:0]         i_rank,
    input  logic [9:0]         i_corner0,
    input  logic [9:0]         i_corner1,
    input  logic [9:0]         i_corner2,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic [9:0]         o_new_corner0,
    output logic [9:0]         o_new_corner1,
    output logic [9:0]         o_new_corner2,
    output logic [1:0]         o_status
);

    t_cmd    cmd;
    t_status st;

    vlsr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    vlsr_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_st          (st),
        .i_func        (i_func),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .i_z_coord     (i_z_coord),
        .i_last_vertex (i_last_vertex),
        .i_rank        (i_rank),
        .i_corner0     (i_corner0),
        .i_corner1     (i_corner1),
        .i_corner2     (i_corner2),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z),
        .o_new_corner0 (o_new_corner0),
        .o_new_corner1 (o_new_corner1),
        .o_new_corner2 (o_new_corner2),
        .o_status      (o_status)
    );

    // A result is loaded only when the output register is free.
    a_resp_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == CMD_RESP) |-> st.out_free)
        else $error("result loaded over a held result");

    // After an input transfer the block works on that item before taking another.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second item taken while one is in work");

    // Error results carry zero payload.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |->
        (o_out_x == 32'sd0 && o_new_corner0 == 10'd0 && o_new_corner2 == 10'd0))
        else $error("error result with nonzero fields");

endmodule

@@ design/vlsr_ctrl.sv @@
// Controller state machine: sequences item handling, the merge sort and the index map build.
module vlsr_ctrl import vlsr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DISP  = 5'd1;
    localparam logic [4:0] S_SORT0 = 5'd2;
    localparam logic [4:0] S_INIT  = 5'd3;
    localparam logic [4:0] S_PASS  = 5'd4;
    localparam logic [4:0] S_RUN   = 5'd5;
    localparam logic [4:0] S_RDID  = 5'd6;
    localparam logic [4:0] S_RDC   = 5'd7;
    localparam logic [4:0] S_MRG   = 5'd8;
    localparam logic [4:0] S_MAP   = 5'd9;
    localparam logic [4:0] S_MAPW  = 5'd10;
    localparam logic [4:0] S_RDV1  = 5'd11;
    localparam logic [4:0] S_RDV2  = 5'd12;
    localparam logic [4:0] S_RDV3  = 5'd13;
    localparam logic [4:0] S_TRI0  = 5'd14;
    localparam logic [4:0] S_TRI1  = 5'd15;
    localparam logic [4:0] S_TRI2  = 5'd16;
    localparam logic [4:0] S_TRI3  = 5'd17;
    localparam logic [4:0] S_RESP  = 5'd18;

    logic [4:0] r_state;
    logic [4:0] n_state;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        o_cmd.op  = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = CMD_ACCEPT;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_st.func)
                    FUNC_LOAD: n_state = i_st.last ? S_SORT0 : S_RESP;
                    FUNC_READ: n_state = i_st.ok ? S_RDV1 : S_RESP;
                    FUNC_TRI:  n_state = i_st.ok ? S_TRI0 : S_RESP;
                    default:   n_state = S_IDLE;
                endcase
            end
            S_SORT0: begin
                o_cmd.op = CMD_SORT_START;
                n_state  = S_INIT;
            end
            S_INIT: begin
                if (i_st.o_ge_n) begin
                    n_state = S_PASS;
                end else begin
                    o_cmd.op = CMD_INIT;
                end
            end
            S_PASS: begin
                if (i_st.width_done) begin
                    o_cmd.op = CMD_SORT_START;
                    n_state  = S_MAP;
                end else begin
                    o_cmd.op = CMD_PASS_START;
                    n_state  = S_RUN;
                end
            end
            S_RUN: begin
                if (i_st.lo_done) begin
                    o_cmd.op = CMD_PASS_END;
                    n_state  = S_PASS;
                end else begin
                    o_cmd.op = CMD_RUN_START;
                    n_state  = S_RDID;
                end
            end
            S_RDID: begin
                if (i_st.run_done) begin
                    o_cmd.op = CMD_RUN_END;
                    n_state  = S_RUN;
                end else begin
                    o_cmd.op = CMD_RD_ID;
                    n_state  = S_RDC;
                end
            end
            S_RDC: begin
                o_cmd.op = CMD_RD_CRD;
                n_state  = S_MRG;
            end
            S_MRG: begin
                o_cmd.op = CMD_MERGE;
                n_state  = S_RDID;
            end
            S_MAP: begin
                if (i_st.o_ge_n) begin
                    o_cmd.op = CMD_SORT_END;
                    n_state  = S_RESP;
                end else begin
                    o_cmd.op = CMD_MAP_RD;
                    n_state  = S_MAPW;
                end
            end
            S_MAPW: begin
                o_cmd.op = CMD_MAP_WR;
                n_state  = S_MAP;
            end
            S_RDV1: begin
                o_cmd.op = CMD_RANK_RD;
                n_state  = S_RDV2;
            end
            S_RDV2: begin
                o_cmd.op = CMD_RANK_CRD;
                n_state  = S_RDV3;
            end
            S_RDV3: begin
                o_cmd.op = CMD_RANK_CAP;
                n_state  = S_RESP;
            end
            S_TRI0: begin
                o_cmd.op = CMD_TRI0;
                n_state  = S_TRI1;
            end
            S_TRI1: begin
                o_cmd.op = CMD_TRI1;
                n_state  = S_TRI2;
            end
            S_TRI2: begin
                o_cmd.op = CMD_TRI2;
                n_state  = S_TRI3;
            end
            S_TRI3: begin
                o_cmd.op = CMD_TRI3;
                n_state  = S_RESP;
            end
            S_RESP: begin
                if (i_st.out_free) begin
                    o_cmd.op = CMD_RESP;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ design/vlsr_datapath.sv @@
// Datapath: coordinate, index and map memories, merge counters, comparator and result register.
module vlsr_datapath import vlsr_pkg::*; #(
    parameter int MAX_VERTICES = VLSR_MAX_VERTICES,
    parameter int COORD_WIDTH  = VLSR_COORD_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_st,
    input  logic [1:0]         i_func,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_y_coord,
    input  logic signed [31:0] i_z_coord,
    input  logic               i_last_vertex,
    input  logic [9:0]         i_rank,
    input  logic [9:0]         i_corner0,
    input  logic [9:0]         i_corner1,
    input  logic [9:0]         i_corner2,
    input  logic               i_stall,
    output logic               o_valid,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic [9:0]         o_new_corner0,
    output logic [9:0]         o_new_corner1,
    output logic [9:0]         o_new_corner2,
    output logic [1:0]         o_status
);

    localparam int IW   = $clog2(MAX_VERTICES);
    localparam int CNTW = $clog2(MAX_VERTICES + 1);
    localparam int SW   = CNTW + 2;
    localparam int KW   = (CNTW > 10) ? CNTW : 10;
    localparam int EW   = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
    localparam int XW   = (IW > 10) ? IW : 10;
    localparam int CW   = COORD_WIDTH;

    logic signed [CW-1:0] mem_x [MAX_VERTICES];
    logic signed [CW-1:0] mem_y [MAX_VERTICES];
    logic signed [CW-1:0] mem_z [MAX_VERTICES];
    logic [IW-1:0]        mem_id0 [MAX_VERTICES];
    logic [IW-1:0]        mem_id1 [MAX_VERTICES];
    logic [IW-1:0]        mem_o2n [MAX_VERTICES];

    logic [CNTW-1:0] r_count;
    logic            r_sorted;
    logic [1:0]      r_func;
    logic            r_last;
    logic [9:0]      r_rank, r_c0, r_c1, r_c2;
    logic [SW-1:0]   r_width, r_lo, r_mid, r_hi, r_p, r_q, r_o;
    logic            r_src;
    logic [IW-1:0]   r_idp, r_idq;
    logic [IW-1:0]   r_id0_a, r_id0_b, r_id1_a, r_id1_b, r_o2n_rd;
    logic signed [CW-1:0] r_xa, r_ya, r_za, r_xb, r_yb, r_zb;
    logic signed [CW-1:0] r_res_x, r_res_y, r_res_z;
    logic [IW-1:0]   r_res_c0, r_res_c1, r_res_c2;
    logic [1:0]      r_res_status;
    logic            r_out_valid;
    logic signed [31:0] r_ox, r_oy, r_oz;
    logic [9:0]      r_oc0, r_oc1, r_oc2;
    logic [1:0]      r_ostat;

    logic [SW-1:0]   n_s, sum_m, mid_v, sum_h, hi_v;
    logic [CNTW-1:0] eff_count;
    logic            room, q_first, take_q;
    logic [IW-1:0]   src_a, src_b, id_ra, o2n_ra, merge_id;
    logic [KW-1:0]   rank_k, c0_k, c1_k, c2_k, cnt_k, irank_k, ic0_k, ic1_k, ic2_k;
    logic signed [EW-1:0] ix_e, iy_e, iz_e, rx_e, ry_e, rz_e;
    logic [XW-1:0]   c0_e, c1_e, c2_e;
    logic            is_load;

    assign n_s       = SW'(r_count);
    assign eff_count = r_sorted ? '0 : r_count;
    assign room      = eff_count < CNTW'(MAX_VERTICES);
    assign is_load   = (i_cmd.op == CMD_ACCEPT) && (i_func == FUNC_LOAD);

    assign sum_m = r_lo + r_width;
    assign mid_v = (sum_m < n_s) ? sum_m : n_s;
    assign sum_h = mid_v + r_width;
    assign hi_v  = (sum_h < n_s) ? sum_h : n_s;

    assign src_a = r_src ? r_id1_a : r_id0_a;
    assign src_b = r_src ? r_id1_b : r_id0_b;

    assign cnt_k   = KW'(r_count);
    assign rank_k  = KW'(r_rank);
    assign c0_k    = KW'(r_c0);
    assign c1_k    = KW'(r_c1);
    assign c2_k    = KW'(r_c2);
    assign irank_k = KW'(i_rank);
    assign ic0_k   = KW'(i_corner0);
    assign ic1_k   = KW'(i_corner1);
    assign ic2_k   = KW'(i_corner2);

    always_comb begin
        id_ra = r_p[IW-1:0];
        if (i_cmd.op == CMD_RANK_RD) begin
            id_ra = rank_k[IW-1:0];
        end else if (i_cmd.op == CMD_MAP_RD) begin
            id_ra = r_o[IW-1:0];
        end
    end

    always_comb begin
        o2n_ra = c0_k[IW-1:0];
        if (i_cmd.op == CMD_TRI1) begin
            o2n_ra = c1_k[IW-1:0];
        end else if (i_cmd.op == CMD_TRI2) begin
            o2n_ra = c2_k[IW-1:0];
        end
    end

    // Vertex q orders strictly before vertex p: compare x, then y, then z.
    assign q_first = (r_xb < r_xa) ||
                     ((r_xb == r_xa) && ((r_yb < r_ya) ||
                     ((r_yb == r_ya) && (r_zb < r_za))));
    assign take_q   = (r_p >= r_mid) || ((r_q < r_hi) && q_first);
    assign merge_id = take_q ? r_idq : r_idp;

    assign ix_e = EW'(i_x_coord);
    assign iy_e = EW'(i_y_coord);
    assign iz_e = EW'(i_z_coord);
    assign rx_e = EW'(r_res_x);
    assign ry_e = EW'(r_res_y);
    assign rz_e = EW'(r_res_z);
    assign c0_e = XW'(r_res_c0);
    assign c1_e = XW'(r_res_c1);
    assign c2_e = XW'(r_res_c2);

    // Memories: registered reads every cycle, writes on command.
    always_ff @(posedge i_clk) begin
        r_id0_a  <= mem_id0[id_ra];
        r_id0_b  <= mem_id0[r_q[IW-1:0]];
        r_id1_a  <= mem_id1[id_ra];
        r_id1_b  <= mem_id1[r_q[IW-1:0]];
        r_xa     <= mem_x[src_a];
        r_ya     <= mem_y[src_a];
        r_za     <= mem_z[src_a];
        r_xb     <= mem_x[src_b];
        r_yb     <= mem_y[src_b];
        r_zb     <= mem_z[src_b];
        r_o2n_rd <= mem_o2n[o2n_ra];
        if (is_load && room) begin
            mem_x[eff_count[IW-1:0]] <= ix_e[CW-1:0];
            mem_y[eff_count[IW-1:0]] <= iy_e[CW-1:0];
            mem_z[eff_count[IW-1:0]] <= iz_e[CW-1:0];
        end
        if (i_cmd.op == CMD_INIT) begin
            mem_id0[r_o[IW-1:0]] <= r_o[IW-1:0];
        end
        if (i_cmd.op == CMD_MERGE) begin
            if (r_src) begin
                mem_id0[r_o[IW-1:0]] <= merge_id;
            end else begin
                mem_id1[r_o[IW-1:0]] <= merge_id;
            end
        end
        if (i_cmd.op == CMD_MAP_WR) begin
            mem_o2n[src_a] <= r_o[IW-1:0];
        end
    end

    // Item capture, sort counters and result fields.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            CMD_ACCEPT: begin
                r_func       <= i_func;
                r_last       <= i_last_vertex;
                r_rank       <= i_rank;
                r_c0         <= i_corner0;
                r_c1         <= i_corner1;
                r_c2         <= i_corner2;
                r_res_x      <= '0;
                r_res_y      <= '0;
                r_res_z      <= '0;
                r_res_c0     <= '0;
                r_res_c1     <= '0;
                r_res_c2     <= '0;
                if (i_func == FUNC_LOAD) begin
                    r_res_status <= room ? ST_OK : ST_FULL;
                end else if (!r_sorted) begin
                    r_res_status <= ST_NOT_SORTED;
                end else if (i_func == FUNC_READ) begin
                    r_res_status <= (irank_k < cnt_k) ? ST_OK : ST_RANGE;
                end else begin
                    r_res_status <= ((ic0_k < cnt_k) && (ic1_k < cnt_k) && (ic2_k < cnt_k))
                                    ? ST_OK : ST_RANGE;
                end
            end
            CMD_SORT_START: begin
                r_o     <= '0;
                r_width <= SW'(1);
            end
            CMD_INIT:       r_o  <= r_o + SW'(1);
            CMD_PASS_START: r_lo <= '0;
            CMD_PASS_END:   r_width <= r_width << 1;
            CMD_RUN_START: begin
                r_mid <= mid_v;
                r_hi  <= hi_v;
                r_p   <= r_lo;
                r_q   <= mid_v;
                r_o   <= r_lo;
            end
            CMD_RUN_END:    r_lo <= r_lo + (r_width << 1);
            CMD_RD_CRD: begin
                r_idp <= src_a;
                r_idq <= src_b;
            end
            CMD_MERGE: begin
                r_o <= r_o + SW'(1);
                if (take_q) begin
                    r_q <= r_q + SW'(1);
                end else begin
                    r_p <= r_p + SW'(1);
                end
            end
            CMD_MAP_WR:     r_o <= r_o + SW'(1);
            CMD_RANK_CAP: begin
                r_res_x <= r_xa;
                r_res_y <= r_ya;
                r_res_z <= r_za;
            end
            CMD_TRI1:       r_res_c0 <= r_o2n_rd;
            CMD_TRI2:       r_res_c1 <= r_o2n_rd;
            CMD_TRI3:       r_res_c2 <= r_o2n_rd;
            default: begin
            end
        endcase
    end

    // Control state: vertex count, sorted flag, merge bank select, result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sorted    <= 1'b0;
            r_src       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (is_load) begin
                r_sorted <= 1'b0;
                r_count  <= room ? eff_count + CNTW'(1) : eff_count;
            end
            // Index setup fills bank 0, so every sort starts merging from it.
            if (i_cmd.op == CMD_INIT) begin
                r_src <= 1'b0;
            end
            if (i_cmd.op == CMD_PASS_END) begin
                r_src <= ~r_src;
            end
            if (i_cmd.op == CMD_SORT_END) begin
                r_sorted <= 1'b1;
            end
            if (i_cmd.op == CMD_RESP) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The output register takes a finished result only when it is free.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == CMD_RESP) begin
            r_ox    <= rx_e[31:0];
            r_oy    <= ry_e[31:0];
            r_oz    <= rz_e[31:0];
            r_oc0   <= c0_e[9:0];
            r_oc1   <= c1_e[9:0];
            r_oc2   <= c2_e[9:0];
            r_ostat <= r_res_status;
        end
    end

    always_comb begin
        o_st.func       = r_func;
        o_st.last       = r_last;
        o_st.ok         = (r_res_status == ST_OK);
        o_st.o_ge_n     = (r_o >= n_s);
        o_st.width_done = (r_width >= n_s);
        o_st.lo_done    = (r_lo >= n_s);
        o_st.run_done   = (r_o >= r_hi);
        o_st.out_free   = !r_out_valid || !i_stall;
    end

    assign o_valid       = r_out_valid;
    assign o_out_x       = r_ox;
    assign o_out_y       = r_oy;
    assign o_out_z       = r_oz;
    assign o_new_corner0 = r_oc0;
    assign o_new_corner1 = r_oc1;
    assign o_new_corner2 = r_oc2;
    assign o_status      = r_ostat;

endmodule
